>>> rtl/cst_pkg.sv
// Shared types, constants and character classes for the stream tokenizer.
package cst_pkg;

    localparam int POS_BITS    = 16;
    localparam int OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLUS1  = 3'd1,
        MODE_MINUS1 = 3'd2,
        MODE_NUM    = 3'd3,
        MODE_IDENT  = 3'd4
    } lex_mode_t;

    typedef enum logic [2:0] {
        KIND_PLUS  = 3'd0,
        KIND_MINUS = 3'd1,
        KIND_INC   = 3'd2,
        KIND_DEC   = 3'd3,
        KIND_NUM   = 3'd4,
        KIND_IDENT = 3'd5,
        KIND_END   = 3'd6,
        KIND_ERR   = 3'd7
    } token_kind_t;

    typedef struct packed {
        token_kind_t              kind;
        logic [OFFSET_BITS-1:0]   start_offset;
        logic [OFFSET_BITS-1:0]   token_length;
        logic                     last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB)
            || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

>>> rtl/char_stream_tokenizer_top.sv
// Byte-serial lexer: one source byte in, zero to two token items out.
//
//  channel | direction | tdata (low bit up)                          | tlast
//  s_      | in        | ch[7:0]                                     | -
//  m_      | out       | token_kind[2:0] start_offset[18:3]          | last
//          |           | token_length[34:19], zero pad [39:35]       |
//
// Each byte is classified in the cycle it is accepted and its results are
// written into a four-entry result queue; one byte per cycle is accepted
// while s_tready is high, and a byte that yields two results fills two
// queue entries. s_tready is high while at least two queue entries are free.
// aresetn (synchronous) empties the queue and returns lexer state to start.
module char_stream_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // token_kind[2:0], start_offset[18:3], token_length[34:19]
    output logic        m_tlast
);

    localparam int PB = cst_pkg::POS_BITS;
    localparam int QD = cst_pkg::QUEUE_DEPTH;
    localparam int QP = cst_pkg::QPTR_BITS;
    localparam int QC = cst_pkg::QCNT_BITS;

    cst_pkg::lex_mode_t mode_reg, mode_next;
    logic [PB-1:0]      pos_reg, pos_next;
    logic [PB-1:0]      tstart_reg, tstart_next;

    cst_pkg::token_t    queue_mem [QD];
    logic [QP-1:0]      head_reg, tail_reg;
    logic [QC-1:0]      count_reg, count_next;

    logic               accept, pop;
    logic [7:0]         c;
    logic               close_tok, double_tok;
    cst_pkg::token_kind_t close_kind;
    logic               sm_valid;
    cst_pkg::token_t    res_a, res_b;
    logic [1:0]         n_res;
    cst_pkg::token_t    sm_res;

    assign c      = s_tdata;
    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    // Next lexer state
    always_comb begin
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        close_tok   = 1'b0;
        double_tok  = 1'b0;
        case (mode_reg)
            cst_pkg::MODE_PLUS1: begin
                double_tok = (c == cst_pkg::CH_PLUS);
                close_tok  = !double_tok;
            end
            cst_pkg::MODE_MINUS1: begin
                double_tok = (c == cst_pkg::CH_MINUS);
                close_tok  = !double_tok;
            end
            cst_pkg::MODE_NUM: begin
                close_tok = !cst_pkg::is_digit(c);
            end
            cst_pkg::MODE_IDENT: begin
                close_tok = !(cst_pkg::is_alpha(c) || cst_pkg::is_digit(c)
                              || (c == cst_pkg::CH_UNDER));
            end
            default: begin
                close_tok = 1'b0;
            end
        endcase

        // start mode sees the byte unless the current token absorbs it
        if (double_tok) begin
            mode_next = cst_pkg::MODE_START;
        end else if (close_tok || (mode_reg != cst_pkg::MODE_NUM
                                   && mode_reg != cst_pkg::MODE_IDENT)) begin
            mode_next = cst_pkg::MODE_START;
            if (c == cst_pkg::CH_PLUS) begin
                tstart_next = pos_reg;
                mode_next   = cst_pkg::MODE_PLUS1;
            end else if (c == cst_pkg::CH_MINUS) begin
                tstart_next = pos_reg;
                mode_next   = cst_pkg::MODE_MINUS1;
            end else if (cst_pkg::is_digit(c)) begin
                tstart_next = pos_reg;
                mode_next   = cst_pkg::MODE_NUM;
            end else if (cst_pkg::is_alpha(c) || (c == cst_pkg::CH_UNDER)) begin
                tstart_next = pos_reg;
                mode_next   = cst_pkg::MODE_IDENT;
            end
        end

        pos_next = pos_reg + PB'(1);
        if (c == cst_pkg::CH_NUL) begin
            pos_next    = '0;
            tstart_next = '0;
            mode_next   = cst_pkg::MODE_START;
        end
    end

    // Result items for this byte
    always_comb begin
        case (mode_reg)
            cst_pkg::MODE_PLUS1:  close_kind = double_tok ? cst_pkg::KIND_INC
                                                          : cst_pkg::KIND_PLUS;
            cst_pkg::MODE_MINUS1: close_kind = double_tok ? cst_pkg::KIND_DEC
                                                          : cst_pkg::KIND_MINUS;
            cst_pkg::MODE_NUM:    close_kind = cst_pkg::KIND_NUM;
            default:              close_kind = cst_pkg::KIND_IDENT;
        endcase

        sm_valid = !double_tok
                   && (close_tok || (mode_reg != cst_pkg::MODE_NUM
                                     && mode_reg != cst_pkg::MODE_IDENT))
                   && !(c == cst_pkg::CH_PLUS || c == cst_pkg::CH_MINUS
                        || cst_pkg::is_digit(c) || cst_pkg::is_alpha(c)
                        || c == cst_pkg::CH_UNDER || cst_pkg::is_space(c));

        sm_res.kind         = (c == cst_pkg::CH_NUL) ? cst_pkg::KIND_END : cst_pkg::KIND_ERR;
        sm_res.start_offset = cst_pkg::OFFSET_BITS'(pos_reg);
        sm_res.token_length = (c == cst_pkg::CH_NUL) ? '0 : cst_pkg::OFFSET_BITS'(1);
        sm_res.last         = 1'b1;

        res_a.kind         = close_kind;
        res_a.start_offset = cst_pkg::OFFSET_BITS'(tstart_reg);
        res_a.token_length = double_tok
                             ? cst_pkg::OFFSET_BITS'(pos_reg + PB'(1) - tstart_reg)
                             : cst_pkg::OFFSET_BITS'(pos_reg - tstart_reg);
        res_a.last         = !sm_valid;
        res_b              = sm_res;

        if (close_tok || double_tok) begin
            n_res = sm_valid ? 2'd2 : 2'd1;
        end else begin
            res_a = sm_res;
            n_res = sm_valid ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= cst_pkg::MODE_START;
            pos_reg    <= '0;
            tstart_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
        end
    end

    // Result queue
    always_ff @(posedge aclk) begin
        if (accept && (n_res != 2'd0)) begin
            queue_mem[tail_reg] <= res_a;
        end
        if (accept && (n_res == 2'd2)) begin
            queue_mem[tail_reg + QP'(1)] <= res_b;
        end
    end

    always_comb begin
        count_next = count_reg - QC'(pop);
        if (accept) begin
            count_next = count_next + QC'(n_res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (pop) begin
                head_reg <= head_reg + QP'(1);
            end
            if (accept) begin
                tail_reg <= tail_reg + QP'(n_res);
            end
        end
    end

    assign s_tready = (count_reg <= QC'(QD - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {5'b0, queue_mem[head_reg].token_length,
                       queue_mem[head_reg].start_offset, queue_mem[head_reg].kind};
    assign m_tlast  = queue_mem[head_reg].last;

endmodule

>>> rtl/cst_checker.sv
// Port-level checks on the tokenizer's input and result streams, bound to the top level.
module cst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    logic [2:0]  kind;
    logic [15:0] len;

    assign kind = m_tdata[2:0];
    assign len  = m_tdata[34:19];

    // an input item waiting on the block stays offered and unchanged
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while stalled");

    // a result waiting on the sink stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_end_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == cst_pkg::KIND_END) |-> (len == 16'd0) && m_tlast)
        else $error("end item malformed");

    a_err_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == cst_pkg::KIND_ERR) |-> (len == 16'd1) && m_tlast)
        else $error("error item malformed");

    a_dbl_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == cst_pkg::KIND_INC || kind == cst_pkg::KIND_DEC)
        |-> (len == 16'd2) && m_tlast)
        else $error("double operator length wrong");

endmodule

bind char_stream_tokenizer_top cst_checker u_cst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
